[rtl/stfn_pkg.sv]
// Shared constants and rounding and saturation helpers for the surface tangent core.
// No dependencies; every rtl file imports it.
package stfn_pkg;

    localparam int DIV_STAGES = 32;   // quotient bits per divide
    localparam int DIV_LAT    = DIV_STAGES + 1;
    localparam int LEN_W      = 32;   // root of a 64-bit sum of squares
    localparam int RT_W       = 24;   // root of a 48-bit radicand
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    // round to nearest, ties toward plus infinity, by 2^30
    function automatic logic signed [63:0] rsh30(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd536870912;
        return w >>> 30;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/stfn_delay.sv]
// Enable-gated delay line with a reset valid lane.
// Uses stfn_pkg only by convention.
module stfn_delay
    import stfn_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [W-1:0]     data_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DEPTH; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int k = 1; k < DEPTH; k++) begin
                data_reg[k] <= data_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

[rtl/stfn_isqrt.sv]
// Pipelined floor square root, one root bit per stage.
// Uses stfn_pkg only by convention.
module stfn_isqrt
    import stfn_pkg::*;
#(
    parameter int RW = 32
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RW-1:0] rad,
    output logic [RW-1:0]   root
);

    localparam int MW = RW + 3;

    logic [2*RW-1:0] rad_reg  [RW];
    logic [MW-1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] rad_next [RW];
    logic [MW-1:0]   rem_next [RW];
    logic [RW-1:0]   root_next[RW];

    always_comb begin
        logic [2*RW-1:0] src_rad;
        logic [MW-1:0]   src_rem;
        logic [RW-1:0]   src_root;
        logic [MW-1:0]   rem_sh;
        logic [MW-1:0]   trial;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                src_rad  = rad;
                src_rem  = '0;
                src_root = '0;
            end else begin
                src_rad  = rad_reg[k-1];
                src_rem  = rem_reg[k-1];
                src_root = root_reg[k-1];
            end
            rem_sh = {src_rem[MW-3:0], src_rad[2*RW-1 -: 2]};
            trial  = {1'b0, src_root, 2'b01};
            rad_next[k] = src_rad << 2;
            if (rem_sh >= trial) begin
                rem_next[k]  = rem_sh - trial;
                root_next[k] = {src_root[RW-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh;
                root_next[k] = {src_root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < RW; k++) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

[rtl/stfn_div.sv]
// Pipelined signed Q2.30 quotient, round(mag*2^30/den) ties away from zero.
// Restoring divide, one quotient bit per stage; depends on stfn_pkg.
module stfn_div
    import stfn_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic [31:0]        mag,
    input  logic               neg,
    input  logic [31:0]        den,
    output logic signed [31:0] quo
);

    logic [32:0] rem_reg [DIV_STAGES];
    logic [31:0] lo_reg  [DIV_STAGES];
    logic [31:0] q_reg   [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    logic        neg_reg [DIV_STAGES];
    logic [32:0] rem_next[DIV_STAGES];
    logic [31:0] lo_next [DIV_STAGES];
    logic [31:0] q_next  [DIV_STAGES];
    logic signed [31:0] quo_reg;

    always_comb begin
        logic [62:0] num;
        logic [32:0] src_rem;
        logic [31:0] src_lo;
        logic [31:0] src_q;
        logic [31:0] src_den;
        logic [32:0] rem_sh;
        num = {1'b0, mag, 30'b0} + 63'(den >> 1);
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                src_rem = {2'b0, num[62:32]};
                src_lo  = num[31:0];
                src_q   = '0;
                src_den = den;
            end else begin
                src_rem = rem_reg[k-1];
                src_lo  = lo_reg[k-1];
                src_q   = q_reg[k-1];
                src_den = den_reg[k-1];
            end
            rem_sh     = {src_rem[31:0], src_lo[31]};
            lo_next[k] = src_lo << 1;
            if (rem_sh >= {1'b0, src_den}) begin
                rem_next[k] = rem_sh - {1'b0, src_den};
                q_next[k]   = {src_q[30:0], 1'b1};
            end else begin
                rem_next[k] = rem_sh;
                q_next[k]   = {src_q[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_next[k];
                q_reg[k]   <= q_next[k];
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            quo_reg <= neg_reg[DIV_STAGES-1] ? -$signed(q_reg[DIV_STAGES-1])
                                             : $signed(q_reg[DIV_STAGES-1]);
        end
    end

    assign quo = quo_reg;

endmodule

[rtl/surface_tangent_from_normal_core.sv]
// Tangent frame from a surface normal: top level.
// Depends on stfn_pkg, stfn_delay, stfn_isqrt, stfn_div.
//
// Input channel s_axis_*: one normal (x, y, z, signed Q16.16) per beat.
// Output channel m_axis_*: the tangent T and second tangent S = T x n per
// beat, Q16.16 saturated; m_axis_tuser is set for a zero normal, whose
// tangent fields are all zero.
// Throughput: one beat per cycle while the receiver takes beats. Path from an
// accepted input beat to the output register: input register, registers
// for the squares, the partial sum and the full sum, a 32-stage square root,
// a 33-stage divider bank (the 24-stage root of L*2^16 runs beside it), then
// the multiply, round and cross-product registers.
// The whole pipeline advances together; while a result sits in the
// output register and the receiver holds m_axis_tready low, every stage
// holds and s_axis_tready is low. Bubbles are carried as cleared valid
// bits. Synchronous active-low reset clears all valid bits; no other
// state is reset.
module surface_tangent_from_normal_core
    import stfn_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // normal_x, normal_y, normal_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tangent_t_x, tangent_t_y, tangent_t_z, tangent_s_x, tangent_s_y, tangent_s_z
    output logic [191:0] m_axis_tdata,
    output logic         m_axis_tuser   // degenerate
);

    logic en;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [31:0] x0_reg, y0_reg, z0_reg;
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    logic signed [31:0] x2_reg, y2_reg, z2_reg;
    logic signed [31:0] x3_reg, y3_reg, z3_reg;
    logic [63:0] xsq_reg, ysq_reg, zsq_reg, hsq_reg, zsq2_reg, lsq_reg, hsq3_reg;

    logic [LEN_W-1:0] lraw, hraw;
    logic [RT_W-1:0]  rt_raw, rt_d;
    logic             vd;
    logic [95:0]      xyz_d;
    logic signed [31:0] xd, yd, zd;
    logic             deg_d, hz_d, vq;
    logic [1:0]       flags_q;
    logic             v_rt;
    logic [1:0]       flags_rt;
    logic [RT_W+1:0]  rtf_d;
    logic signed [31:0] nx_q, ny_q, nz_q, ct_q, cs_q, ss_q;

    logic e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, out_valid_reg;
    logic d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, out_deg_reg;
    logic signed [63:0] pcs_reg, pss_reg;
    logic signed [31:0] ct1_reg, ct2_reg;
    logic [RT_W-1:0] rt1_reg, rt2_reg;
    logic signed [31:0] nx1_reg, ny1_reg, nz1_reg, nx2_reg, ny2_reg, nz2_reg;
    logic signed [31:0] nx3_reg, ny3_reg, nz3_reg, nx4_reg, ny4_reg, nz4_reg;
    logic signed [31:0] a_reg, b_reg;
    logic signed [63:0] mx_reg, my_reg, mz_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [31:0] tx5_reg, ty5_reg, tz5_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic [191:0] out_data_reg;
    logic signed [63:0] r_cs, r_ss;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // valid lane of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // squares and sums of squares
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg   <= s_axis_tdata[31:0];
            y0_reg   <= s_axis_tdata[63:32];
            z0_reg   <= s_axis_tdata[95:64];
            xsq_reg  <= 64'(x0_reg * x0_reg);
            ysq_reg  <= 64'(y0_reg * y0_reg);
            zsq_reg  <= 64'(z0_reg * z0_reg);
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            z1_reg   <= z0_reg;
            hsq_reg  <= xsq_reg + ysq_reg;
            zsq2_reg <= zsq_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            lsq_reg  <= hsq_reg + zsq2_reg;
            hsq3_reg <= hsq_reg;
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
        end
    end

    stfn_isqrt #(.RW(LEN_W)) u_sqrt_len (
        .aclk(aclk), .en(en), .rad(lsq_reg), .root(lraw)
    );
    stfn_isqrt #(.RW(LEN_W)) u_sqrt_hyp (
        .aclk(aclk), .en(en), .rad(hsq3_reg), .root(hraw)
    );
    stfn_delay #(.W(96), .DEPTH(LEN_W)) u_dly_xyz (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v3_reg), .in_data({z3_reg, y3_reg, x3_reg}),
        .out_valid(vd), .out_data(xyz_d)
    );

    assign xd = xyz_d[31:0];
    assign yd = xyz_d[63:32];
    assign zd = xyz_d[95:64];

    // sqrt(L) as the root of L*2^16, realigned to the divider latency;
    // the flags and valid ride beside the root so they leave together
    stfn_isqrt #(.RW(RT_W)) u_sqrt_rt (
        .aclk(aclk), .en(en), .rad({lraw[2*RT_W-17:0], 16'b0}), .root(rt_raw)
    );
    stfn_delay #(.W(2), .DEPTH(RT_W)) u_dly_flags (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(vd), .in_data({hraw == '0, lraw == '0}),
        .out_valid(v_rt), .out_data(flags_rt)
    );
    stfn_delay #(.W(RT_W + 2), .DEPTH(DIV_LAT - RT_W)) u_dly_rt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_rt), .in_data({flags_rt, rt_raw}),
        .out_valid(vq), .out_data(rtf_d)
    );
    assign rt_d    = rtf_d[RT_W-1:0];
    assign flags_q = rtf_d[RT_W+1:RT_W];
    assign deg_d   = flags_q[0];
    assign hz_d    = flags_q[1];

    stfn_div u_div_nx (.aclk(aclk), .en(en), .mag(xd[31] ? 32'(-xd) : 32'(xd)),
                       .neg(xd[31]), .den(lraw), .quo(nx_q));
    stfn_div u_div_ny (.aclk(aclk), .en(en), .mag(yd[31] ? 32'(-yd) : 32'(yd)),
                       .neg(yd[31]), .den(lraw), .quo(ny_q));
    stfn_div u_div_nz (.aclk(aclk), .en(en), .mag(zd[31] ? 32'(-zd) : 32'(zd)),
                       .neg(zd[31]), .den(lraw), .quo(nz_q));
    stfn_div u_div_ct (.aclk(aclk), .en(en), .mag(hraw),
                       .neg(1'b0), .den(lraw), .quo(ct_q));
    stfn_div u_div_cs (.aclk(aclk), .en(en), .mag(xd[31] ? 32'(-xd) : 32'(xd)),
                       .neg(xd[31]), .den(hraw), .quo(cs_q));
    stfn_div u_div_ss (.aclk(aclk), .en(en), .mag(yd[31] ? 32'(-yd) : 32'(yd)),
                       .neg(yd[31]), .den(hraw), .quo(ss_q));

    assign r_cs = rsh30(pcs_reg);
    assign r_ss = rsh30(pss_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg        <= 1'b0;
            e2_reg        <= 1'b0;
            e3_reg        <= 1'b0;
            e4_reg        <= 1'b0;
            e5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            e1_reg        <= vq;
            e2_reg        <= e1_reg;
            e3_reg        <= e2_reg;
            e4_reg        <= e3_reg;
            e5_reg        <= e4_reg;
            out_valid_reg <= e5_reg;
        end
    end

    // back end: angle products, scale by sqrt(L), cross product
    always_ff @(posedge aclk) begin
        if (en) begin
            // normal along z: cos s = 1, sin s = 0
            pcs_reg <= 64'((hz_d ? Q30_ONE : cs_q) * nz_q);
            pss_reg <= 64'((hz_d ? 32'sd0 : ss_q) * nz_q);
            ct1_reg <= ct_q;
            rt1_reg <= rt_d;
            nx1_reg <= nx_q;
            ny1_reg <= ny_q;
            nz1_reg <= nz_q;
            d1_reg  <= deg_d;

            a_reg   <= 32'(-r_cs);
            b_reg   <= 32'(-r_ss);
            ct2_reg <= ct1_reg;
            rt2_reg <= rt1_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            nz2_reg <= nz1_reg;
            d2_reg  <= d1_reg;

            mx_reg  <= 64'($signed({1'b0, rt2_reg}) * a_reg);
            my_reg  <= 64'($signed({1'b0, rt2_reg}) * b_reg);
            mz_reg  <= 64'($signed({1'b0, rt2_reg}) * ct2_reg);
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;
            d3_reg  <= d2_reg;

            tx_reg  <= 32'(rsh30(mx_reg));
            ty_reg  <= 32'(rsh30(my_reg));
            tz_reg  <= 32'(rsh30(mz_reg));
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;
            nz4_reg <= nz3_reg;
            d4_reg  <= d3_reg;

            p1_reg  <= 64'(ty_reg * nz4_reg);
            p2_reg  <= 64'(tz_reg * ny4_reg);
            p3_reg  <= 64'(tz_reg * nx4_reg);
            p4_reg  <= 64'(tx_reg * nz4_reg);
            p5_reg  <= 64'(tx_reg * ny4_reg);
            p6_reg  <= 64'(ty_reg * nx4_reg);
            tx5_reg <= tx_reg;
            ty5_reg <= ty_reg;
            tz5_reg <= tz_reg;
            d5_reg  <= d4_reg;

            out_deg_reg <= d5_reg;
            if (d5_reg) begin
                out_data_reg <= '0;
            end else begin
                out_data_reg <= {sat32(rsh30(p5_reg - p6_reg)),
                                 sat32(rsh30(p3_reg - p4_reg)),
                                 sat32(rsh30(p1_reg - p2_reg)),
                                 sat32(64'(tz5_reg)),
                                 sat32(64'(ty5_reg)),
                                 sat32(64'(tx5_reg))};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_deg_reg;

    // zero normal must come out as an all-zero frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate beat with nonzero tangents");

    // T.z = sqrt(L) * cos t is never negative
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[95])
        else $error("negative tangent_t_z");

    // a held output beat stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
